// ===== rtl/bfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants of the shortest-path core: field widths, the
// request codes, the unreachable cost and the sequencer states.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  // Fixed field widths
  localparam int unsigned VTX_W    = 6;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COST_W   = 32;
  localparam int unsigned VCNT_W   = 7;

  // Request codes
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Cost reported for a vertex that is never reached
  localparam logic signed [COST_W-1:0] COST_INF = 32'sd99999;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_ROW_RD,
    S_ROW_LD,
    S_PAIR_RD,
    S_PAIR_EV,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_e;

endpackage

// ===== rtl/bfsp_adj_ram.sv =====
// ----------------------------------------------------------------------------
// bfsp_adj_ram
// Adjacency weight memory, one port. After reset a sweep writes zero to
// every entry, one per cycle, and busy stays high until it is done.
// ----------------------------------------------------------------------------
module bfsp_adj_ram import bfsp_pkg::*; #(
  parameter int unsigned AW = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic signed [WEIGHT_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic signed [WEIGHT_W-1:0] rd_data_o,
  output logic                       clr_busy_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic signed [WEIGHT_W-1:0] mem [DEPTH];
  logic                       clr_busy_q;
  logic [AW-1:0]              clr_cnt_q;

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == {AW{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Write port: the sweep has priority
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  assign clr_busy_o = clr_busy_q;

endmodule

// ===== rtl/bfsp_dist_ram.sv =====
// ----------------------------------------------------------------------------
// bfsp_dist_ram
// Distance memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfsp_dist_ram import bfsp_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic signed [COST_W-1:0] wr_data_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic signed [COST_W-1:0] rd_data_o
);

  logic signed [COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/bfsp_relax.sv =====
// ----------------------------------------------------------------------------
// bfsp_relax
// Shared relaxation unit: one add of source distance and edge weight, one
// signed compare against the destination distance.
// ----------------------------------------------------------------------------
module bfsp_relax import bfsp_pkg::*; (
  input  logic signed [COST_W-1:0]   src_dist_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  input  logic signed [COST_W-1:0]   dst_dist_i,
  input  logic                       dst_reached_i,
  output logic signed [COST_W-1:0]   cand_o,
  output logic                       improve_o
);

  assign cand_o = src_dist_i + COST_W'(weight_i);

  // No edge never relaxes; an unreached destination takes any candidate
  assign improve_o = (weight_i != '0) && (!dst_reached_i || (cand_o < dst_dist_i));

endmodule

// ===== rtl/bellman_ford_shortest_paths_core.sv =====
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_core
// Single-source shortest paths over an adjacency matrix of signed weights.
// ----------------------------------------------------------------------------
// An edge write (req_type 0) gives no result; a zero weight removes the
// edge. A run (req_type 1) sets all vertices unreached, the start to zero
// if it is below n, makes n-1 relaxation passes and a check pass over all
// vertex pairs, where n is vertex_count clamped to 1..MAX_VERTICES. Each
// pass reads row u's distance and, for a reached row, handles each pair
// with an adjacency/distance read, then add/compare/write in the single
// relaxation unit. The result is either one negative-cycle item or n cost
// items in vertex order, the last one marked. The input is stalled for
// the whole run. After reset the adjacency memory is cleared one entry per
// cycle, and no item is taken before then; configuration writes are taken
// at any time.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths_core import bfsp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [VCNT_W-1:0]          cfg_wdata_i,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [VTX_W-1:0]           src_vertex_i,
  input  logic [VTX_W-1:0]           dst_vertex_i,
  input  logic signed [WEIGHT_W-1:0] edge_weight_i,
  input  logic [VTX_W-1:0]           start_vertex_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [VTX_W-1:0]           vertex_index_o,
  output logic signed [COST_W-1:0]   path_cost_o,
  output logic                       reachable_o,
  output logic                       negative_cycle_o,
  output logic                       last_result_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW = 2 * VW;

  state_e                   state_q, state_d;
  logic [VCNT_W-1:0]        vcount_q;
  logic [VW-1:0]            u_q, u_d, v_q, v_d, start_q, start_d;
  logic [CW-1:0]            pass_q, pass_d;
  logic                     start_ok_q, start_ok_d;
  logic                     changed_q, changed_d;
  logic signed [COST_W-1:0] du_q, du_d;
  logic [MAX_VERTICES-1:0]  reached_q, reached_d;

  logic [CW-1:0]            n, n_m1;
  logic                     u_last, v_last, apply, row_done, edge_ok;
  logic                     load_cost, load_neg;

  logic                       adj_we, adj_re, clr_busy;
  logic signed [WEIGHT_W-1:0] adj_rdata;
  logic                       dist_we, dist_re;
  logic [VW-1:0]              dist_waddr, dist_raddr;
  logic signed [COST_W-1:0]   dist_wdata, dist_rdata, cand;
  logic                       improve;

  logic [VTX_W-1:0]         out_idx_q;
  logic signed [COST_W-1:0] out_cost_q;
  logic                     out_reach_q, out_neg_q, out_last_q;

  // Vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 7'd64;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // Active vertex count, zero taken as one, saturated at capacity
  always_comb begin
    if (vcount_q == '0) begin
      n = CW'(1);
    end else if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(vcount_q);
    end
  end

  assign n_m1    = n - CW'(1);
  assign u_last  = (CW'(u_q) == n_m1);
  assign v_last  = (CW'(v_q) == n_m1);
  assign apply   = (pass_q != n_m1);
  assign edge_ok = (32'(src_vertex_i) < 32'(MAX_VERTICES)) &&
                   (32'(dst_vertex_i) < 32'(MAX_VERTICES));

  // Memories and the shared relaxation unit
  bfsp_adj_ram #(.AW(AW)) u_adj (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (adj_we),
    .wr_addr_i  ({VW'(src_vertex_i), VW'(dst_vertex_i)}),
    .wr_data_i  (edge_weight_i),
    .rd_en_i    (adj_re),
    .rd_addr_i  ({u_q, v_q}),
    .rd_data_o  (adj_rdata),
    .clr_busy_o (clr_busy)
  );

  bfsp_dist_ram #(.DEPTH(MAX_VERTICES), .AW(VW)) u_dist (
    .clk_i     (clk_i),
    .wr_en_i   (dist_we),
    .wr_addr_i (dist_waddr),
    .wr_data_i (dist_wdata),
    .rd_en_i   (dist_re),
    .rd_addr_i (dist_raddr),
    .rd_data_o (dist_rdata)
  );

  bfsp_relax u_relax (
    .src_dist_i    (du_q),
    .weight_i      (adj_rdata),
    .dst_dist_i    (dist_rdata),
    .dst_reached_i (reached_q[v_q]),
    .cand_o        (cand),
    .improve_o     (improve)
  );

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      u_q        <= '0;
      v_q        <= '0;
      pass_q     <= '0;
      start_q    <= '0;
      start_ok_q <= 1'b0;
      changed_q  <= 1'b0;
      reached_q  <= '0;
    end else begin
      state_q    <= state_d;
      u_q        <= u_d;
      v_q        <= v_d;
      pass_q     <= pass_d;
      start_q    <= start_d;
      start_ok_q <= start_ok_d;
      changed_q  <= changed_d;
      reached_q  <= reached_d;
    end
  end

  always_ff @(posedge clk_i) begin
    du_q <= du_d;
  end

  // Next state and control
  always_comb begin
    state_d    = state_q;
    u_d        = u_q;
    v_d        = v_q;
    pass_d     = pass_q;
    start_d    = start_q;
    start_ok_d = start_ok_q;
    changed_d  = changed_q;
    reached_d  = reached_q;
    du_d       = du_q;
    adj_we     = 1'b0;
    adj_re     = 1'b0;
    dist_we    = 1'b0;
    dist_re    = 1'b0;
    dist_waddr = v_q;
    dist_wdata = cand;
    dist_raddr = u_q;
    row_done   = 1'b0;
    load_cost  = 1'b0;
    load_neg   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        if (!clr_busy) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_EDGE) begin
            adj_we = edge_ok;
          end else begin
            start_d    = VW'(start_vertex_i);
            start_ok_d = (32'(start_vertex_i) < 32'(n));
            state_d    = S_INIT;
          end
        end
      end
      S_INIT: begin
        reached_d = '0;
        if (start_ok_q) begin
          reached_d[start_q] = 1'b1;
          dist_we            = 1'b1;
          dist_waddr         = start_q;
          dist_wdata         = '0;
        end
        u_d       = '0;
        pass_d    = '0;
        changed_d = 1'b0;
        state_d   = S_ROW_RD;
      end
      S_ROW_RD: begin
        dist_re = 1'b1;
        state_d = S_ROW_LD;
      end
      S_ROW_LD: begin
        // unreached rows never act as a source
        if (reached_q[u_q]) begin
          du_d    = dist_rdata;
          v_d     = '0;
          state_d = S_PAIR_RD;
        end else begin
          row_done = 1'b1;
        end
      end
      S_PAIR_RD: begin
        adj_re     = 1'b1;
        dist_re    = 1'b1;
        dist_raddr = v_q;
        state_d    = S_PAIR_EV;
      end
      S_PAIR_EV: begin
        if (improve) begin
          if (apply) begin
            dist_we       = 1'b1;
            reached_d[v_q] = 1'b1;
            // self edge: later pairs of this row see the new source value
            if (v_q == u_q) begin
              du_d = cand;
            end
          end else begin
            changed_d = 1'b1;
          end
        end
        if (v_last) begin
          row_done = 1'b1;
        end else begin
          v_d     = v_q + VW'(1);
          state_d = S_PAIR_RD;
        end
      end
      S_OUT_RD: begin
        dist_re = 1'b1;
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        load_cost = 1'b1;
        state_d   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (!out_stall_i) begin
          if (out_last_q) begin
            state_d = S_IDLE;
          end else begin
            u_d     = u_q + VW'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // End of a row: next row, next pass, or finish the run
    if (row_done) begin
      if (!u_last) begin
        u_d     = u_q + VW'(1);
        state_d = S_ROW_RD;
      end else if (apply) begin
        pass_d  = pass_q + CW'(1);
        u_d     = '0;
        state_d = S_ROW_RD;
      end else if (changed_d) begin
        load_neg = 1'b1;
        state_d  = S_OUT_WAIT;
      end else begin
        u_d     = '0;
        state_d = S_OUT_RD;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_neg) begin
      out_idx_q   <= '0;
      out_cost_q  <= '0;
      out_reach_q <= 1'b0;
      out_neg_q   <= 1'b1;
      out_last_q  <= 1'b1;
    end else if (load_cost) begin
      out_idx_q   <= VTX_W'(u_q);
      out_cost_q  <= reached_q[u_q] ? dist_rdata : COST_INF;
      out_reach_q <= reached_q[u_q];
      out_neg_q   <= 1'b0;
      out_last_q  <= u_last;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = (state_q == S_OUT_WAIT);
  assign vertex_index_o   = out_idx_q;
  assign path_cost_o      = out_cost_q;
  assign reachable_o      = out_reach_q;
  assign negative_cycle_o = out_neg_q;
  assign last_result_o    = out_last_q;

  // Assertions
  a_neg_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && negative_cycle_o |-> last_result_o && !reachable_o)
    else $error("negative-cycle result not final");

  a_unreached_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o && !negative_cycle_o |-> path_cost_o == COST_INF)
    else $error("unreached vertex without infinite cost");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("transfer accepted during adjacency clear");

  a_start_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT && start_ok_q |=> reached_q[$past(start_q)])
    else $error("start vertex not marked reached");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PAIR_EV |-> (32'(u_q) < 32'(n)) && (32'(v_q) < 32'(n)))
    else $error("pair index beyond active vertex count");

endmodule
